FILE: hw/rtl/tsx_pkg.sv
// Shared types, constants and lookup functions for the telnet/XML stream splitter.
// No dependencies; imported by every module of the block.
package tsx_pkg;

	localparam int unsigned TAG_MAX = 32;
	localparam int unsigned TLW     = $clog2(TAG_MAX + 2);

	localparam logic [2:0] K_TEXT       = 3'd0;
	localparam logic [2:0] K_TELNET     = 3'd1;
	localparam logic [2:0] K_TAG        = 3'd2;
	localparam logic [2:0] K_TEXT_END   = 3'd3;
	localparam logic [2:0] K_TELNET_END = 3'd4;

	localparam logic [7:0] C_IAC  = 8'hFF;
	localparam logic [7:0] C_SB   = 8'hFA;
	localparam logic [7:0] C_LF   = 8'h0A;
	localparam logic [7:0] C_LT   = 8'h3C;
	localparam logic [7:0] C_GT   = 8'h3E;
	localparam logic [7:0] C_AMP  = 8'h26;
	localparam logic [7:0] C_SEMI = 8'h3B;
	localparam logic [7:0] C_SL   = 8'h2F;

	typedef struct packed {
		logic [2:0] kind;
		logic [7:0] bval;
		logic [2:0] tkind;
		logic       closing;
		logic [2:0] dir;
		logic       line_end;
	} res_t;

	typedef struct packed {
		res_t [3:0] r;
		logic [1:0] last_idx;
	} burst_t;

	typedef struct packed {
		logic       overlong;
		logic [2:0] tkind;
		logic       closing;
		logic       selfc;
		logic [2:0] dir;
	} tag_info_t;

	function automatic res_t mk_res(input logic [2:0] k, input logic [7:0] b,
			input logic [2:0] tk, input logic cl, input logic [2:0] d, input logic le);
		res_t r;
		r.kind = k;
		r.bval = b;
		r.tkind = tk;
		r.closing = cl;
		r.dir = d;
		r.line_end = le;
		return r;
	endfunction

	function automatic logic is_ws(input logic [7:0] b);
		return (b == 8'h20) || (b >= 8'h09 && b <= 8'h0D);
	endfunction

	function automatic logic [3:0] name_len(input logic [2:0] k);
		case (k)
			3'd0: return 4'd6;
			3'd1: return 4'd4;
			3'd2: return 4'd4;
			3'd3: return 4'd11;
			3'd4: return 4'd5;
			3'd5: return 4'd7;
			3'd6: return 4'd8;
			default: return 4'd0;
		endcase
	endfunction

	// character i of tag name k, valid for i below name_len(k)
	function automatic logic [7:0] name_char(input logic [2:0] k, input logic [3:0] i);
		logic [87:0] s;
		logic [87:0] t;
		logic [3:0]  p;
		case (k)
			3'd0: s = 88'("prompt");
			3'd1: s = 88'("room");
			3'd2: s = 88'("name");
			3'd3: s = 88'("description");
			3'd4: s = 88'("exits");
			3'd5: s = 88'("terrain");
			3'd6: s = 88'("movement");
			default: s = '0;
		endcase
		p = name_len(k) - 4'd1 - i;
		t = s >> {p, 3'b000};
		return t[7:0];
	endfunction

	function automatic logic [2:0] dir_code(input logic [7:0] b);
		case (b)
			8'h6E: return 3'd1;
			8'h65: return 3'd2;
			8'h73: return 3'd3;
			8'h77: return 3'd4;
			8'h75: return 3'd5;
			8'h64: return 3'd6;
			default: return 3'd0;
		endcase
	endfunction

endpackage

FILE: hw/rtl/tsx_tag.sv
// Incremental tag classifier: tracks name match, end/self-closing marks and dir= per byte.
// Depends on tsx_pkg.
module tsx_tag import tsx_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic       push,
	input  logic [7:0] bin,
	output tag_info_t  info
);
	logic [TLW-1:0] len_q;
	logic           closing_q, name_done_q, last_slash_q, dfound_q;
	logic [4:0]     nlen_q, prev_nlen_q;
	logic [6:0]     ok_q, prev_ok_q;
	logic [2:0]     dmatch_q, dir_q;
	logic [6:0]     ok_nx;
	logic [6:0]     fin_ok;
	logic [4:0]     fin_nlen;
	logic [2:0]     kind;
	logic [7:0]     dexp;

	always_comb begin
		for (int k = 0; k < 7; k++) begin
			ok_nx[k] = ok_q[k] && (nlen_q < 5'(name_len(3'(k))))
				&& (name_char(3'(k), nlen_q[3:0]) == bin);
		end
		case (dmatch_q)
			3'd0: dexp = 8'h64;
			3'd1: dexp = 8'h69;
			3'd2: dexp = 8'h72;
			default: dexp = 8'h3D;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
			closing_q <= 1'b0;
			name_done_q <= 1'b0;
			last_slash_q <= 1'b0;
			dfound_q <= 1'b0;
			nlen_q <= '0;
			prev_nlen_q <= '0;
			ok_q <= '1;
			prev_ok_q <= '1;
			dmatch_q <= '0;
			dir_q <= '0;
		end else if (start) begin
			len_q <= TLW'(1);
			closing_q <= 1'b0;
			name_done_q <= 1'b0;
			last_slash_q <= 1'b0;
			dfound_q <= 1'b0;
			nlen_q <= '0;
			prev_nlen_q <= '0;
			ok_q <= '1;
			prev_ok_q <= '1;
			dmatch_q <= '0;
			dir_q <= '0;
		end else if (push) begin
			if (len_q >= TLW'(TAG_MAX)) begin
				len_q <= TLW'(TAG_MAX + 1);
			end else begin
				len_q <= len_q + TLW'(1);
				if (len_q == TLW'(1) && bin == C_SL) begin
					closing_q <= 1'b1;
					last_slash_q <= 1'b0;
				end else begin
					last_slash_q <= (bin == C_SL);
					if (!name_done_q) begin
						if (is_ws(bin)) begin
							name_done_q <= 1'b1;
						end else begin
							prev_ok_q <= ok_q;
							prev_nlen_q <= nlen_q;
							ok_q <= ok_nx;
							nlen_q <= nlen_q + 5'd1;
						end
					end else if (!dfound_q) begin
						if (dmatch_q == 3'd4) begin
							dir_q <= dir_code(bin);
							dfound_q <= 1'b1;
						end else if (bin == dexp) begin
							dmatch_q <= dmatch_q + 3'd1;
						end else if (bin == 8'h64) begin
							dmatch_q <= 3'd1;
						end else begin
							dmatch_q <= 3'd0;
						end
					end
				end
			end
		end
	end

	always_comb begin
		if (!name_done_q && last_slash_q) begin
			fin_ok = prev_ok_q;
			fin_nlen = prev_nlen_q;
		end else begin
			fin_ok = ok_q;
			fin_nlen = nlen_q;
		end
		kind = 3'd0;
		for (int k = 0; k < 7; k++) begin
			if (fin_ok[k] && fin_nlen == 5'(name_len(3'(k))))
				kind = 3'(k + 1);
		end
		info.overlong = (len_q > TLW'(TAG_MAX));
		info.tkind = kind;
		info.closing = closing_q;
		info.selfc = last_slash_q;
		info.dir = (kind == 3'd7 && dfound_q) ? dir_q : 3'd0;
	end

endmodule

FILE: hw/rtl/tsx_front.sv
// Front end: accepts bytes, runs the telnet/tag/entity parser, forms at most one burst per byte.
// Depends on tsx_pkg and tsx_tag.
module tsx_front import tsx_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       take,
	input  logic [7:0] bin,
	input  logic       cfg_we,
	input  logic       cfg_bit,
	output logic       push,
	output burst_t     burst
);
	typedef enum logic [1:0] {PM_NORMAL, PM_TELNET, PM_XML, PM_ENTITY} pmode_t;
	typedef enum logic [3:0] {
		SM_NONE, SM_GOTIAC, SM_SKIP, SM_GOTSB, SM_GOTSBIAC, SM_AMP, SM_L, SM_G,
		SM_A, SM_AM, SM_LT, SM_GT, SM_AMPDONE
	} smode_t;

	pmode_t    pm_q, pm_nx;
	smode_t    sm_q, sm_nx;
	logic      tp_q, tp_nx, xml_q;
	logic      tag_start, tag_push;
	tag_info_t ti;
	res_t [3:0] r;
	logic [2:0] n;
	logic       done;

	tsx_tag u_tag (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (tag_start),
		.push   (tag_push),
		.bin    (bin),
		.info   (ti)
	);

	always_comb begin
		pm_nx = pm_q;
		sm_nx = sm_q;
		tp_nx = tp_q;
		tag_start = 1'b0;
		tag_push = 1'b0;
		done = 1'b0;
		n = 3'd0;
		r = '0;
		case (pm_q)
			PM_TELNET: begin
				r[n[1:0]] = mk_res(K_TELNET, bin, 3'd0, 1'b0, 3'd0, 1'b0); n = n + 3'd1;
				case (sm_q)
					SM_GOTIAC: begin
						if (bin >= 8'd251 && bin <= 8'd254) sm_nx = SM_SKIP;
						else if (bin == C_SB) sm_nx = SM_GOTSB;
						else done = 1'b1;
					end
					SM_GOTSB: begin
						if (bin == C_IAC) sm_nx = SM_GOTSBIAC;
					end
					SM_GOTSBIAC: begin
						if (bin == C_IAC) sm_nx = SM_GOTSB;
						else done = 1'b1;
					end
					default: done = 1'b1;
				endcase
				if (done) begin
					r[n[1:0]] = mk_res(K_TELNET_END, 8'd0, 3'd0, 1'b0, 3'd0, 1'b0);
					n = n + 3'd1;
					pm_nx = PM_NORMAL;
					sm_nx = SM_NONE;
				end
			end
			PM_XML: begin
				if (bin == C_GT) begin
					if (ti.overlong) begin
						r[0] = mk_res(K_TAG, 8'd0, 3'd0, 1'b0, 3'd0, 1'b0);
						n = 3'd1;
					end else begin
						r[0] = mk_res(K_TAG, 8'd0, ti.tkind, ti.closing, ti.dir, 1'b0);
						r[1] = mk_res(K_TAG, 8'd0, ti.tkind, 1'b1, 3'd0, 1'b0);
						n = ti.selfc ? 3'd2 : 3'd1;
					end
					pm_nx = PM_NORMAL;
					sm_nx = SM_NONE;
				end else begin
					tag_push = take;
				end
			end
			PM_ENTITY: begin
				sm_nx = SM_NONE;
				pm_nx = PM_NORMAL;
				tp_nx = 1'b1;
				case (sm_q)
					SM_AMP: begin
						if (bin == 8'h6C) sm_nx = SM_L;
						else if (bin == 8'h67) sm_nx = SM_G;
						else if (bin == 8'h61) sm_nx = SM_A;
					end
					SM_L: if (bin == 8'h74) sm_nx = SM_LT;
					SM_G: if (bin == 8'h74) sm_nx = SM_GT;
					SM_A: if (bin == 8'h6D) sm_nx = SM_AM;
					SM_AM: if (bin == 8'h70) sm_nx = SM_AMPDONE;
					default: sm_nx = SM_NONE;
				endcase
				if (sm_q == SM_LT || sm_q == SM_GT || sm_q == SM_AMPDONE) begin
					r[0] = mk_res(K_TEXT, (sm_q == SM_LT) ? C_LT : ((sm_q == SM_GT) ? C_GT : C_AMP),
						3'd0, 1'b0, 3'd0, 1'b0);
					r[1] = mk_res(K_TEXT, bin, 3'd0, 1'b0, 3'd0, 1'b0);
					n = (bin == C_SEMI) ? 3'd1 : 3'd2;
					sm_nx = SM_NONE;
				end else if (sm_nx != SM_NONE) begin
					pm_nx = PM_ENTITY;
					tp_nx = tp_q;
				end else begin
					r[0] = mk_res(K_TEXT, C_AMP, 3'd0, 1'b0, 3'd0, 1'b0);
					n = 3'd1;
					case (sm_q)
						SM_L: begin r[1] = mk_res(K_TEXT, 8'h6C, 3'd0, 1'b0, 3'd0, 1'b0); n = 3'd2; end
						SM_G: begin r[1] = mk_res(K_TEXT, 8'h67, 3'd0, 1'b0, 3'd0, 1'b0); n = 3'd2; end
						SM_A: begin r[1] = mk_res(K_TEXT, 8'h61, 3'd0, 1'b0, 3'd0, 1'b0); n = 3'd2; end
						SM_AM: begin
							r[1] = mk_res(K_TEXT, 8'h61, 3'd0, 1'b0, 3'd0, 1'b0);
							r[2] = mk_res(K_TEXT, 8'h6D, 3'd0, 1'b0, 3'd0, 1'b0);
							n = 3'd3;
						end
						default: n = 3'd1;
					endcase
					r[n[1:0]] = mk_res(K_TEXT, bin, 3'd0, 1'b0, 3'd0, 1'b0);
					n = n + 3'd1;
				end
			end
			default: begin
				if (bin == C_IAC) begin
					if (tp_q) begin
						r[0] = mk_res(K_TEXT_END, 8'd0, 3'd0, 1'b0, 3'd0, 1'b0); n = 3'd1;
					end
					r[n[1:0]] = mk_res(K_TELNET, bin, 3'd0, 1'b0, 3'd0, 1'b0); n = n + 3'd1;
					tp_nx = 1'b0;
					pm_nx = PM_TELNET;
					sm_nx = SM_GOTIAC;
				end else if (bin == C_LF) begin
					r[0] = mk_res(K_TEXT, bin, 3'd0, 1'b0, 3'd0, 1'b1);
					r[1] = mk_res(K_TEXT_END, 8'd0, 3'd0, 1'b0, 3'd0, 1'b0);
					n = 3'd2;
					tp_nx = 1'b0;
				end else if (bin == C_LT && xml_q) begin
					if (tp_q) begin
						r[0] = mk_res(K_TEXT_END, 8'd0, 3'd0, 1'b0, 3'd0, 1'b0); n = 3'd1;
					end
					tp_nx = 1'b0;
					tag_start = take;
					pm_nx = PM_XML;
				end else if (bin == C_AMP && xml_q) begin
					pm_nx = PM_ENTITY;
					sm_nx = SM_AMP;
				end else begin
					r[0] = mk_res(K_TEXT, bin, 3'd0, 1'b0, 3'd0, 1'b0); n = 3'd1;
					tp_nx = 1'b1;
				end
			end
		endcase
		push = take && (n != 3'd0);
		burst.r = r;
		burst.last_idx = 2'(n - 3'd1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pm_q <= PM_NORMAL;
			sm_q <= SM_NONE;
			tp_q <= 1'b0;
			xml_q <= 1'b0;
		end else begin
			if (cfg_we) xml_q <= cfg_bit;
			if (take) begin
				pm_q <= pm_nx;
				sm_q <= sm_nx;
				tp_q <= tp_nx;
			end
		end
	end

endmodule

FILE: hw/rtl/tsx_queue.sv
// Four-entry burst queue between the parser and the result unpacker.
// Depends on tsx_pkg.
module tsx_queue import tsx_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  burst_t     wdata,
	input  logic       pop,
	output burst_t     head,
	output logic       empty,
	output logic       full,
	output logic [2:0] level
);
	burst_t     mem_q [4];
	logic [1:0] wp_q, rp_q;
	logic [2:0] cnt_q;

	assign empty = (cnt_q == 3'd0);
	assign full = (cnt_q == 3'd4);
	assign level = cnt_q;
	assign head = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 2'd1;
			if (pop) rp_q <= rp_q + 2'd1;
			cnt_q <= cnt_q + 3'(push) - 3'(pop);
		end
	end

endmodule

FILE: hw/rtl/tsx_back.sv
// Back end: walks the head burst one result per request onto the output stream.
// Depends on tsx_pkg.
module tsx_back import tsx_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  burst_t      head,
	input  logic        empty,
	output logic        pop,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,
	output logic [2:0]  m_axis_tuser,
	output logic        m_axis_tlast
);
	logic [1:0] idx_q;
	res_t       cur;
	logic       fire;

	assign cur = head.r[idx_q];
	assign m_axis_tvalid = !empty;
	assign m_axis_tuser = cur.kind;
	assign m_axis_tdata = {cur.line_end, cur.dir, cur.closing, cur.tkind, cur.bval};
	assign m_axis_tlast = (idx_q == head.last_idx);
	assign fire = m_axis_tvalid && m_axis_tready;
	assign pop = fire && m_axis_tlast;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (fire) begin
			idx_q <= m_axis_tlast ? 2'd0 : idx_q + 2'd1;
		end
	end

endmodule

FILE: hw/rtl/telnet_xml_stream_splitter.sv
// Top level of the telnet/XML stream splitter: parser front, burst queue, result back end.
// Depends on tsx_pkg, tsx_front, tsx_queue and tsx_back.
//
//  channel   dir  signals                          contents
//  s_axis    in   tvalid tready tdata[7:0]         byte_in
//  m_axis    out  tvalid tready tdata[15:0] tuser  tuser=kind, tdata see port
//                 tlast                            tlast=last
//  cfg       in   cfg_valid cfg_ready cfg_data     xml_mode
//
// One byte accepted per cycle while the four-burst queue has room; each byte makes
// zero to four results, delivered one per cycle while m_axis_tready is high, so bursty bytes
// are limited by the output drain rate. Reset is asynchronous and clears parser
// state, xml_mode and the queue. Output stalls back up into s_axis_tready only
// once the queue is full.
module telnet_xml_stream_splitter import tsx_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] byte_in
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,   // [7:0] byte_value [10:8] tag_kind [11] tag_closing
	                                    // [14:12] direction [15] line_end
	output logic [2:0]  m_axis_tuser,   // [2:0] kind
	output logic        m_axis_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [0:0]  cfg_data
);
	logic       take, push, pop, empty, full;
	logic [2:0] level;
	burst_t     wburst, head;

	assign cfg_ready = 1'b1;
	assign s_axis_tready = !full;
	assign take = s_axis_tvalid && s_axis_tready;

	tsx_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.take    (take),
		.bin     (s_axis_tdata),
		.cfg_we  (cfg_valid && cfg_ready),
		.cfg_bit (cfg_data[0]),
		.push    (push),
		.burst   (wburst)
	);

	tsx_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (wburst),
		.pop    (pop),
		.head   (head),
		.empty  (empty),
		.full   (full),
		.level  (level)
	);

	tsx_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head          (head),
		.empty         (empty),
		.pop           (pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	a_level: assert property (@(posedge clk) disable iff (!arst_n)
		level <= 3'd4) else $error("queue level overflow");

	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tuser <= K_TELNET_END) else $error("bad result kind");

	a_tag_byte: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser == K_TAG |-> m_axis_tdata[7:0] == 8'd0)
		else $error("tag event carries a byte");

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		full && !pop |=> level == 3'd4) else $error("queue lost an entry");

endmodule
